>>> rtl/tbrl_pkg.sv
// Shared widths, request and register codes, and the bucket capacity function.
package tbrl_pkg;

  localparam int NUM_DOMAINS_DEF = 64;
  localparam int TIME_BITS_DEF   = 32;

  localparam int TYPE_W     = 3;
  localparam int DOM_W      = 6;
  localparam int TOK_W      = 16;
  localparam int NOW_W      = 32;
  localparam int RATE_W     = 20;
  localparam int BURST_W    = 16;
  localparam int DLY_W      = 24;
  localparam int MULT_W     = 16;
  localparam int CNT_W      = 32;
  localparam int LVL_W      = 32;
  localparam int WAIT_W     = 32;
  localparam int REQ_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MILLI      = 1000;

  typedef logic [TYPE_W-1:0] req_type_t;

  localparam req_type_t REQ_ACQUIRE = 3'd0;
  localparam req_type_t REQ_FAILURE = 3'd1;
  localparam req_type_t REQ_SUCCESS = 3'd2;
  localparam req_type_t REQ_CLEAR   = 3'd3;
  localparam req_type_t REQ_WAIT    = 3'd4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DOMAIN_RATE   = 3'd0;
  localparam cfg_idx_t CFG_DOMAIN_BURST  = 3'd1;
  localparam cfg_idx_t CFG_GLOBAL_ENABLE = 3'd2;
  localparam cfg_idx_t CFG_GLOBAL_RATE   = 3'd3;
  localparam cfg_idx_t CFG_BACKOFF_INIT  = 3'd4;
  localparam cfg_idx_t CFG_BACKOFF_MULT  = 3'd5;
  localparam cfg_idx_t CFG_BACKOFF_MAX   = 3'd6;

  // Capacity in milli-tokens: burst tokens, else twice the rate, else one token.
  function automatic logic [LVL_W-1:0] cap_of(input logic [RATE_W-1:0] rate,
                                               input logic [BURST_W-1:0] burst);
    logic [LVL_W-1:0] b;
    logic [LVL_W-1:0] r;
    b = LVL_W'(burst);
    r = LVL_W'(rate);
    if (burst != '0) begin
      return b * LVL_W'(MILLI);
    end else if (rate == '0) begin
      return LVL_W'(MILLI);
    end
    return r * LVL_W'(2 * MILLI);
  endfunction

endpackage

>>> rtl/tbrl_if.sv
// Request, response and configuration channel interfaces.
interface tbrl_req_if;
  logic                          valid;
  logic                          ready;
  logic [tbrl_pkg::TYPE_W-1:0]   req_type;
  logic [tbrl_pkg::DOM_W-1:0]    domain_id;
  logic [tbrl_pkg::TOK_W-1:0]    tokens;
  logic [tbrl_pkg::NOW_W-1:0]    now_ms;
  modport source (output valid, req_type, domain_id, tokens, now_ms, input ready);
  modport sink (input valid, req_type, domain_id, tokens, now_ms, output ready);
endinterface

interface tbrl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          granted;
  logic [tbrl_pkg::WAIT_W-1:0]   wait_ms;
  logic [tbrl_pkg::DLY_W-1:0]    delay_ms;
  logic                          backing_off;
  logic [tbrl_pkg::LVL_W-1:0]    tokens_now;
  logic [tbrl_pkg::CNT_W-1:0]    total_count;
  logic [tbrl_pkg::CNT_W-1:0]    denied_count;
  logic [tbrl_pkg::CNT_W-1:0]    backoff_count;
  modport source (output valid, granted, wait_ms, delay_ms, backing_off, tokens_now,
                  total_count, denied_count, backoff_count, input ready);
  modport sink (input valid, granted, wait_ms, delay_ms, backing_off, tokens_now,
                total_count, denied_count, backoff_count, output ready);
endinterface

interface tbrl_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbrl_pkg::CFG_IDX_W-1:0]    index;
  logic [tbrl_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/tbrl_mem.sv
// Single-port-write, registered-read memory holding one domain entry per word.
module tbrl_mem #(
  parameter int DEPTH = tbrl_pkg::NUM_DOMAINS_DEF,
  parameter int AW    = 6,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tbrl_div.sv
// Restoring divider, one quotient bit per cycle, for the wait-time answer.
module tbrl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tbrl_pkg::REQ_W-1:0]    dividend,
  input  logic [tbrl_pkg::RATE_W-1:0]   divisor,
  output logic                          done,
  output logic [tbrl_pkg::REQ_W-1:0]    quotient
);

  localparam int QW = tbrl_pkg::REQ_W;
  localparam int RW = tbrl_pkg::RATE_W;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] dvd;
  logic [RW-1:0] rem;
  logic [RW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [RW:0]   rem_sh;
  logic          q_bit;

  // Bring down the next dividend bit and try a subtract.
  assign rem_sh = {rem, dvd[QW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dsr});
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= q_bit ? RW'(rem_sh - {1'b0, dsr}) : rem_sh[RW-1:0];
        dvd <= {dvd[QW-2:0], q_bit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/token_bucket_rate_limiter_backoff.sv
// Per-domain token bucket rate limiter with global bucket and exponential backoff.
//
// Channels: req carries one request (acquire, failure, success, clear backoff,
// wait query) with a domain index, a token count and a millisecond timestamp.
// rsp returns exactly one result per request with the domain statistics. cfg
// writes one of the seven configuration registers, always ready; write it only
// while no request is in flight.
// Each request is a read-modify-write of one domain entry in the entry memory:
// accept, read, elapsed time, refill multiply, clamp, update, write back. The
// block takes a new request only once the last one has left write-back, and a
// wait query that needs tokens also passes through the bit-serial divider, one
// quotient bit per cycle.
// A domain index at or above NUM_DOMAINS gives an all-zero result, going straight to write-back.
// After reset the block sweeps every entry of the memory to zero with req.ready
// low; configuration writes are taken during the sweep.
// The result sits in an output register; while the receiver stalls, the next
// request is still accepted and processed, and it waits in write-back until the
// output register frees up.
module token_bucket_rate_limiter_backoff #(
  parameter int NUM_DOMAINS = tbrl_pkg::NUM_DOMAINS_DEF,
  parameter int TIME_BITS   = tbrl_pkg::TIME_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  tbrl_req_if.sink    req,
  tbrl_rsp_if.source  rsp,
  tbrl_cfg_if.sink    cfg
);

  localparam int AW    = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
  localparam int TB    = TIME_BITS;
  localparam int LW    = tbrl_pkg::LVL_W;
  localparam int DW    = tbrl_pkg::DLY_W;
  localparam int CW    = tbrl_pkg::CNT_W;
  localparam int RTW   = tbrl_pkg::RATE_W;
  localparam int QW    = tbrl_pkg::REQ_W;
  localparam int EW    = 1 + LW + TB + DW + TB + 3 * CW;
  localparam int PDW   = 32 + RTW;
  localparam int PBW   = DW + tbrl_pkg::MULT_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EL   = 4'd3;
  localparam logic [3:0] S_MUL  = 4'd4;
  localparam logic [3:0] S_REF  = 4'd5;
  localparam logic [3:0] S_OP   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;

  // Configuration registers.
  logic [RTW-1:0]                 domain_rate;
  logic [tbrl_pkg::BURST_W-1:0]   domain_burst;
  logic                           global_enable;
  logic [RTW-1:0]                 global_rate;
  logic [DW-1:0]                  backoff_initial_ms;
  logic [tbrl_pkg::MULT_W-1:0]    backoff_mult;
  logic [DW-1:0]                  backoff_max_ms;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      domain_rate        <= RTW'(10);
      domain_burst       <= '0;
      global_enable      <= 1'b0;
      global_rate        <= RTW'(10);
      backoff_initial_ms <= DW'(1000);
      backoff_mult       <= tbrl_pkg::MULT_W'(512);
      backoff_max_ms     <= DW'(60000);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        tbrl_pkg::CFG_DOMAIN_RATE:   domain_rate        <= cfg.data[RTW-1:0];
        tbrl_pkg::CFG_DOMAIN_BURST:  domain_burst       <= cfg.data[tbrl_pkg::BURST_W-1:0];
        tbrl_pkg::CFG_GLOBAL_ENABLE: global_enable      <= cfg.data[0];
        tbrl_pkg::CFG_GLOBAL_RATE:   global_rate        <= cfg.data[RTW-1:0];
        tbrl_pkg::CFG_BACKOFF_INIT:  backoff_initial_ms <= cfg.data[DW-1:0];
        tbrl_pkg::CFG_BACKOFF_MULT:  backoff_mult       <= cfg.data[tbrl_pkg::MULT_W-1:0];
        tbrl_pkg::CFG_BACKOFF_MAX:   backoff_max_ms     <= cfg.data[DW-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] cap_d;
  logic [LW-1:0] cap_g;
  assign cap_d = tbrl_pkg::cap_of(domain_rate, domain_burst);
  assign cap_g = tbrl_pkg::cap_of(global_rate, '0);

  // Elapsed time modulo the timer width, clamped to 32 bits.
  function automatic logic [31:0] elapsed(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB-1:0] d;
    logic [47:0]   d48;
    d   = a - b;
    d48 = 48'(d);
    return (d48 > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : d48[31:0];
  endfunction

  // Control and request registers.
  logic [3:0]                 state;
  logic [AW-1:0]              clr_cnt;
  tbrl_pkg::req_type_t        r_type;
  logic [AW-1:0]              r_addr;
  logic [QW-1:0]              r_req;
  logic [TB-1:0]              r_now;
  logic                       r_oor;

  // Working copy of the domain entry.
  logic                       w_valid;
  logic [LW-1:0]              w_level;
  logic [TB-1:0]              w_stamp;
  logic [DW-1:0]              w_delay;
  logic [TB-1:0]              w_fstamp;
  logic [CW-1:0]              w_total;
  logic [CW-1:0]              w_denied;
  logic [CW-1:0]              w_backoff;

  // Global bucket and its working copy.
  logic                       g_valid;
  logic [LW-1:0]              g_level;
  logic [TB-1:0]              g_stamp;
  logic [LW-1:0]              gw_level;
  logic [TB-1:0]              gw_stamp;

  // Pipeline of the refill arithmetic.
  logic [31:0]                el_d;
  logic [31:0]                el_g;
  logic                       fel_ok;
  logic [PDW-1:0]             prod_d;
  logic [PDW-1:0]             prod_g;
  logic [PBW-1:0]             prod_b;
  logic [LW-1:0]              r_lvl_d;
  logic [LW-1:0]              r_lvl_g;
  logic [DW-1:0]              grow_d;
  logic                       o_granted;
  logic [tbrl_pkg::WAIT_W-1:0] o_wait;

  // Output register.
  logic                       rsp_valid;
  logic                       out_granted;
  logic [tbrl_pkg::WAIT_W-1:0] out_wait;
  logic [DW-1:0]              out_delay;
  logic [LW-1:0]              out_tokens;
  logic [CW-1:0]              out_total;
  logic [CW-1:0]              out_denied;
  logic [CW-1:0]              out_backoff;

  assign rsp.valid         = rsp_valid;
  assign rsp.granted       = out_granted;
  assign rsp.wait_ms       = out_wait;
  assign rsp.delay_ms      = out_delay;
  assign rsp.backing_off   = (out_delay != '0);
  assign rsp.tokens_now    = out_tokens;
  assign rsp.total_count   = out_total;
  assign rsp.denied_count  = out_denied;
  assign rsp.backoff_count = out_backoff;

  assign req.ready = (state == S_IDLE);

  // Entry memory.
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [EW-1:0]              mem_wdata;
  logic [EW-1:0]              mem_rdata;
  logic                       wb_fire;

  logic                       e_valid;
  logic [LW-1:0]              e_level;
  logic [TB-1:0]              e_stamp;
  logic [DW-1:0]              e_delay;
  logic [TB-1:0]              e_fstamp;
  logic [CW-1:0]              e_total;
  logic [CW-1:0]              e_denied;
  logic [CW-1:0]              e_backoff;

  assign {e_valid, e_level, e_stamp, e_delay, e_fstamp, e_total, e_denied, e_backoff} =
      mem_rdata;

  assign wb_fire   = (state == S_WB) && (!rsp_valid || rsp.ready);
  assign mem_we    = (state == S_CLR) || (wb_fire && !r_oor);
  assign mem_waddr = (state == S_CLR) ? clr_cnt : r_addr;
  assign mem_wdata = (state == S_CLR) ? '0 :
      {w_valid, w_level, w_stamp, w_delay, w_fstamp, w_total, w_denied, w_backoff};

  tbrl_mem #(
    .DEPTH (NUM_DOMAINS),
    .AW    (AW),
    .W     (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (AW'(req.domain_id)),
    .rdata (mem_rdata)
  );

  // Refill sums and backoff growth, before the clamp.
  logic [PDW:0]   sum_d;
  logic [PDW:0]   sum_g;
  logic [31:0]    grow;
  assign sum_d = (PDW + 1)'(w_level) + (PDW + 1)'(prod_d);
  assign sum_g = (PDW + 1)'(gw_level) + (PDW + 1)'(prod_g);
  assign grow  = prod_b[PBW-1:8];

  // Request update on the refilled entry.
  logic           n_valid;
  logic [LW-1:0]  n_level;
  logic [TB-1:0]  n_stamp;
  logic [DW-1:0]  n_delay;
  logic [TB-1:0]  n_fstamp;
  logic [CW-1:0]  n_total;
  logic [CW-1:0]  n_denied;
  logic [CW-1:0]  n_backoff;
  logic           n_granted;
  logic           n_wait_sat;
  logic           n_div;
  logic           n_g_upd;
  logic [LW-1:0]  n_g_level;
  logic [QW-1:0]  n_need;
  logic [LW-1:0]  req_l;
  logic [LW-1:0]  need_full;
  logic [DW-1:0]  half;
  logic           ok0;
  logic           ok1;

  assign req_l     = LW'(r_req);
  assign need_full = req_l - r_lvl_d;
  assign n_need    = need_full[QW-1:0];
  assign half      = w_delay >> 1;

  always_comb begin
    n_valid    = w_valid;
    n_level    = w_level;
    n_stamp    = w_stamp;
    n_delay    = w_delay;
    n_fstamp   = w_fstamp;
    n_total    = w_total;
    n_denied   = w_denied;
    n_backoff  = w_backoff;
    n_granted  = 1'b0;
    n_wait_sat = 1'b0;
    n_div      = 1'b0;
    n_g_upd    = 1'b0;
    n_g_level  = r_lvl_g;
    ok0        = 1'b1;
    ok1        = 1'b1;
    case (r_type)
      tbrl_pkg::REQ_ACQUIRE: begin
        n_valid = 1'b1;
        n_level = r_lvl_d;
        n_stamp = r_now;
        n_total = w_total + CW'(1);
        n_g_upd = global_enable;
        ok0 = !(global_enable && (r_lvl_g < req_l));
        if (ok0 && (w_delay != '0) && fel_ok) begin
          n_delay = '0;
        end
        ok1 = ok0 && ((w_delay == '0) || fel_ok);
        if (ok1 && (r_lvl_d >= req_l)) begin
          n_level   = r_lvl_d - req_l;
          n_g_level = r_lvl_g - req_l;
          n_granted = 1'b1;
        end else begin
          n_denied = w_denied + CW'(1);
        end
      end
      tbrl_pkg::REQ_FAILURE: begin
        n_fstamp  = r_now;
        n_backoff = w_backoff + CW'(1);
        n_delay   = (w_delay == '0) ? backoff_initial_ms : grow_d;
      end
      tbrl_pkg::REQ_SUCCESS: begin
        if (w_delay != '0) begin
          n_delay = (half < backoff_initial_ms) ? '0 : half;
        end
      end
      tbrl_pkg::REQ_CLEAR: begin
        n_delay = '0;
      end
      tbrl_pkg::REQ_WAIT: begin
        if (w_valid) begin
          n_level = r_lvl_d;
          n_stamp = r_now;
          if (r_lvl_d < req_l) begin
            if (domain_rate == '0) begin
              n_wait_sat = 1'b1;
            end else begin
              n_div = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Divider for the wait-time answer.
  logic           div_done;
  logic [QW-1:0]  div_q;

  tbrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_OP) && n_div),
    .dividend (n_need),
    .divisor  (domain_rate),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: clear sweep, then read, refill, update, divide if needed and write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
      g_valid   <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one moves in.
      if (rsp_valid && rsp.ready && !wb_fire) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(NUM_DOMAINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            r_type <= req.req_type;
            r_addr <= AW'(req.domain_id);
            r_req  <= QW'(req.tokens) * QW'(tbrl_pkg::MILLI);
            r_now  <= TB'(req.now_ms);
            r_oor  <= (32'(req.domain_id) >= 32'(NUM_DOMAINS));
            state  <= (32'(req.domain_id) >= 32'(NUM_DOMAINS)) ? S_WB : S_RD;
          end
        end
        S_RD: begin
          w_valid   <= e_valid;
          w_level   <= e_valid ? e_level : cap_d;
          w_stamp   <= e_valid ? e_stamp : r_now;
          w_delay   <= e_delay;
          w_fstamp  <= e_fstamp;
          w_total   <= e_total;
          w_denied  <= e_denied;
          w_backoff <= e_backoff;
          gw_level  <= g_valid ? g_level : cap_g;
          gw_stamp  <= g_valid ? g_stamp : r_now;
          state     <= S_EL;
        end
        S_EL: begin
          el_d   <= elapsed(r_now, w_stamp);
          el_g   <= elapsed(r_now, gw_stamp);
          fel_ok <= (48'(TB'(r_now - w_fstamp)) >= 48'(w_delay));
          state  <= S_MUL;
        end
        S_MUL: begin
          prod_d <= PDW'(el_d) * PDW'(domain_rate);
          prod_g <= PDW'(el_g) * PDW'(global_rate);
          prod_b <= PBW'(w_delay) * PBW'(backoff_mult);
          state  <= S_REF;
        end
        S_REF: begin
          r_lvl_d <= (sum_d < (PDW + 1)'(cap_d)) ? sum_d[LW-1:0] : cap_d;
          r_lvl_g <= (sum_g < (PDW + 1)'(cap_g)) ? sum_g[LW-1:0] : cap_g;
          grow_d  <= (grow > 32'(backoff_max_ms)) ? backoff_max_ms : grow[DW-1:0];
          state   <= S_REF + 4'd1;
        end
        S_OP: begin
          w_valid   <= n_valid;
          w_level   <= n_level;
          w_stamp   <= n_stamp;
          w_delay   <= n_delay;
          w_fstamp  <= n_fstamp;
          w_total   <= n_total;
          w_denied  <= n_denied;
          w_backoff <= n_backoff;
          o_granted <= n_granted;
          o_wait    <= n_wait_sat ? '1 : '0;
          if (n_g_upd) begin
            g_valid <= 1'b1;
            g_level <= n_g_level;
            g_stamp <= r_now;
          end
          state <= n_div ? S_DIV : S_WB;
        end
        S_DIV: begin
          if (div_done) begin
            o_wait <= ((w_delay != '0) && (32'(w_delay) > 32'(div_q))) ?
                      32'(w_delay) : 32'(div_q);
            state  <= S_WB;
          end
        end
        S_WB: begin
          if (wb_fire) begin
            rsp_valid   <= 1'b1;
            out_granted <= r_oor ? 1'b0 : o_granted;
            out_wait    <= r_oor ? '0 : o_wait;
            out_delay   <= r_oor ? '0 : w_delay;
            out_tokens  <= (r_oor || !w_valid) ? '0 : w_level;
            out_total   <= r_oor ? '0 : w_total;
            out_denied  <= r_oor ? '0 : w_denied;
            out_backoff <= r_oor ? '0 : w_backoff;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/tbrl_chk.sv
// Port-level checks for the rate limiter, bound to the top level.
module tbrl_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          granted,
  input logic [tbrl_pkg::WAIT_W-1:0]   wait_ms,
  input logic [tbrl_pkg::DLY_W-1:0]    delay_ms,
  input logic                          backing_off
);

  // The memory sweep keeps requests out right after reset.
  a_clear_after_rst: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request accepted during the clearing sweep");

  // No result is offered right after reset.
  a_no_rsp_after_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result offered right after reset");

  // The backoff flag follows the delay.
  a_backoff_flag: assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> (backing_off == (delay_ms != '0)))
    else $error("backing_off disagrees with delay_ms");

  // A granted acquire never carries a wait answer.
  a_grant_no_wait: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && granted) |-> (wait_ms == '0))
    else $error("granted result with nonzero wait");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(delay_ms) && $stable(wait_ms)))
    else $error("stalled result changed");

endmodule

bind token_bucket_rate_limiter_backoff tbrl_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .granted     (rsp.granted),
  .wait_ms     (rsp.wait_ms),
  .delay_ms    (rsp.delay_ms),
  .backing_off (rsp.backing_off)
);
